[sv/bsa_pkg.sv]
// shared types, codes and default sizes for the bitplane slot allocator
`default_nettype none

package bsa_pkg;

    // default sizes
    localparam int DEF_MAX_BLOCKS = 16;
    localparam int DEF_PLANES     = 8;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_ID_BITS    = 16;

    // request function codes
    localparam logic FN_ALLOC   = 1'b0;
    localparam logic FN_RELEASE = 1'b1;

    // response status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic capture;  // request accepted: latch per-cell hit flags
        logic cap_rel;  // compare mode at capture (release compares ids)
        logic fire;     // update edge
        logic upd_rel;  // request under update is a release
        logic found;    // some cell hit
        logic remove;   // released block became empty: close up the row
    } cell_ctl_t;

endpackage

`default_nettype wire

[sv/bitplane_slot_allocator.sv]
// top level of the bitplane slot allocator: request latch, cell row, response register
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  request | req_valid | req_stall | func, grid_key, block_id, plane
//  response| rsp_valid | rsp_stall | status, out_block_id, out_plane, new_block
//
// a request is handled as a compare and then an update: every cell compares its block
// against the request at the accept edge, and the table and response register update as the update state ends
// the update waits while an earlier response is still stalled at the output
// a new request is taken once the update is done, even with a response pending
// reset empties the table and sets the next block id to zero; no clearing pass
`default_nettype none

module bitplane_slot_allocator
    import bsa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int PLANES     = DEF_PLANES,
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int ID_BITS    = DEF_ID_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic        func,
    input  wire logic [31:0] grid_key,
    input  wire logic [15:0] block_id,
    input  wire logic [2:0]  plane,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [1:0]       status,
    output logic [15:0]      out_block_id,
    output logic [2:0]       out_plane,
    output logic             new_block
);

    // sequencer states
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic                state_reg, state_next;
    logic                accept;
    logic                fire;

    // latched request
    logic                func_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [2:0]          plane_reg;
    logic [ID_BITS-1:0]  next_id_reg, next_id_next;

    // response register
    logic                rsp_valid_reg, rsp_valid_next;
    logic [1:0]          status_reg, status_next;
    logic [15:0]         rsp_id_reg, rsp_id_next;
    logic [2:0]          rsp_plane_reg, rsp_plane_next;
    logic                new_block_reg, new_block_next;

    // row wiring, one spare position past the end reads as an empty slot
    logic [MAX_BLOCKS:0]   valid_x;
    logic [KEY_BITS-1:0]   key_x  [MAX_BLOCKS+1];
    logic [PLANES-1:0]     used_x [MAX_BLOCKS+1];
    logic [ID_BITS-1:0]    id_x   [MAX_BLOCKS+1];
    logic [MAX_BLOCKS:0]   before_c;
    logic [MAX_BLOCKS-1:0] first_v;
    logic [MAX_BLOCKS-1:0] empty_v;

    cell_ctl_t           ctl;
    logic [KEY_BITS-1:0] cmp_key;
    logic [ID_BITS-1:0]  cmp_id;
    logic [PLANES-1:0]   req_mask;
    logic                found;
    logic                full;
    logic                remove;
    logic [PLANES-1:0]   sel_used;
    logic [ID_BITS-1:0]  sel_id;
    logic [2:0]          free_idx;

    assign req_stall = (state_reg == ST_UPD);
    assign accept    = req_valid & ~req_stall;
    assign fire      = (state_reg == ST_UPD) & (~rsp_valid_reg | ~rsp_stall);

    assign cmp_key = KEY_BITS'(grid_key);
    assign cmp_id  = ID_BITS'(block_id);

    // plane numbers at or above the plane count clear nothing
    assign req_mask = ({1'b0, plane_reg} < 4'(PLANES)) ? (PLANES'(1) << plane_reg) : '0;

    // request latch and sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (fire)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            key_reg   <= cmp_key;
            id_reg    <= cmp_id;
            plane_reg <= plane;
        end
    end

    // broadcast control to the row
    assign found  = before_c[MAX_BLOCKS];
    assign full   = valid_x[MAX_BLOCKS-1];
    assign remove = (func_reg == FN_RELEASE) & (|(first_v & empty_v));

    always_comb
    begin
        ctl.capture = accept;
        ctl.cap_rel = (func == FN_RELEASE);
        ctl.fire    = fire;
        ctl.upd_rel = (func_reg == FN_RELEASE);
        ctl.found   = found;
        ctl.remove  = remove;
    end

    // the cell row; cell 0 is the head of the list
    assign before_c[0]         = 1'b0;
    assign valid_x[MAX_BLOCKS] = 1'b0;
    assign key_x[MAX_BLOCKS]   = '0;
    assign used_x[MAX_BLOCKS]  = '0;
    assign id_x[MAX_BLOCKS]    = '0;

    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        logic prev_valid;

        if (i == 0)
        begin : g_head
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_valid = valid_x[i-1];
        end

        bsa_cell #(
            .PLANES   (PLANES),
            .KEY_BITS (KEY_BITS),
            .ID_BITS  (ID_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .cmp_key    (cmp_key),
            .cmp_id     (cmp_id),
            .req_key    (key_reg),
            .req_mask   (req_mask),
            .new_id     (next_id_reg),
            .prev_valid (prev_valid),
            .before_in  (before_c[i]),
            .before_out (before_c[i+1]),
            .nxt_valid  (valid_x[i+1]),
            .nxt_key    (key_x[i+1]),
            .nxt_used   (used_x[i+1]),
            .nxt_id     (id_x[i+1]),
            .valid      (valid_x[i]),
            .key        (key_x[i]),
            .used       (used_x[i]),
            .id         (id_x[i]),
            .first      (first_v[i]),
            .empty      (empty_v[i])
        );
    end

    // contents of the first hit cell (at most one is flagged)
    always_comb
    begin
        sel_used = '0;
        sel_id   = '0;
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            sel_used = sel_used | (used_x[i] & {PLANES{first_v[i]}});
            sel_id   = sel_id | (id_x[i] & {ID_BITS{first_v[i]}});
        end
    end

    // lowest free plane of the selected block
    always_comb
    begin
        free_idx = '0;
        for (int k = PLANES - 1; k >= 0; k--)
        begin
            if (!sel_used[k])
                free_idx = 3'(k);
        end
    end

    // response build and next id
    always_comb
    begin
        next_id_next   = next_id_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        status_next    = status_reg;
        rsp_id_next    = rsp_id_reg;
        rsp_plane_next = rsp_plane_reg;
        new_block_next = new_block_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
            new_block_next = 1'b0;
            if (func_reg == FN_RELEASE)
            begin
                status_next    = found ? ST_OK : ST_NOTFOUND;
                rsp_id_next    = 16'(id_reg);
                rsp_plane_next = plane_reg;
            end
            else if (found)
            begin
                status_next    = ST_OK;
                rsp_id_next    = 16'(sel_id);
                rsp_plane_next = free_idx;
            end
            else if (full)
            begin
                status_next    = ST_FULL;
                rsp_id_next    = '0;
                rsp_plane_next = '0;
            end
            else
            begin
                // fresh block appended at the end of the list
                status_next    = ST_OK;
                rsp_id_next    = 16'(next_id_reg);
                rsp_plane_next = '0;
                new_block_next = 1'b1;
                next_id_next   = next_id_reg + ID_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            next_id_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_id_reg   <= next_id_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        rsp_id_reg    <= rsp_id_next;
        rsp_plane_reg <= rsp_plane_next;
        new_block_reg <= new_block_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign out_block_id = rsp_id_reg;
    assign out_plane    = rsp_plane_reg;
    assign new_block    = new_block_reg;

    // checks

    // the first-hit chain never flags two cells
    a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_v))
        else $error("more than one first hit in the row");

    // occupied slots always form a prefix of the row
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_x[MAX_BLOCKS-1:0] + MAX_BLOCKS'(1)) & valid_x[MAX_BLOCKS-1:0]) == '0)
        else $error("gap in the occupied slots");

    // an update always leaves a response behind
    a_fire_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid_reg)
        else $error("update without a response");

    // an accepted request is followed by its update state
    a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_UPD))
        else $error("accepted request not in update");

    // closing up only happens on a release that hit a block
    a_remove_rel: assert property (@(posedge clk) disable iff (!rst_n)
        remove |-> (found && (func_reg == FN_RELEASE)))
        else $error("row close-up without a release hit");

endmodule

`default_nettype wire

[sv/bsa_cell.sv]
// one table slot of the allocator row: holds a block, compares, shifts left
`default_nettype none

module bsa_cell
    import bsa_pkg::*;
#(
    parameter int PLANES   = DEF_PLANES,
    parameter int KEY_BITS = DEF_KEY_BITS,
    parameter int ID_BITS  = DEF_ID_BITS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cell_ctl_t           ctl,
    // compare operands, taken straight from the request port at capture
    input  wire logic [KEY_BITS-1:0] cmp_key,
    input  wire logic [ID_BITS-1:0]  cmp_id,
    // update operands, from the latched request and the next-id counter
    input  wire logic [KEY_BITS-1:0] req_key,
    input  wire logic [PLANES-1:0]   req_mask,
    input  wire logic [ID_BITS-1:0]  new_id,
    // chain links
    input  wire logic                prev_valid,
    input  wire logic                before_in,
    output logic                     before_out,
    input  wire logic                nxt_valid,
    input  wire logic [KEY_BITS-1:0] nxt_key,
    input  wire logic [PLANES-1:0]   nxt_used,
    input  wire logic [ID_BITS-1:0]  nxt_id,
    // own contents
    output logic                     valid,
    output logic [KEY_BITS-1:0]      key,
    output logic [PLANES-1:0]        used,
    output logic [ID_BITS-1:0]       id,
    output logic                     first,
    output logic                     empty
);

    logic                valid_reg, valid_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [PLANES-1:0]   used_reg, used_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic                hit_reg, hit_next;
    logic [PLANES-1:0]   low_free;
    logic [PLANES-1:0]   cleared;
    logic                append;
    logic                shift;

    assign before_out = before_in | hit_reg;
    assign first      = hit_reg & ~before_in;

    // lowest clear bit isolated
    assign low_free = ~used_reg & (used_reg + PLANES'(1));
    assign cleared  = used_reg & ~req_mask;
    assign empty    = first & ~(|cleared);

    assign append = ctl.fire & ~ctl.upd_rel & ~ctl.found & ~valid_reg & prev_valid;
    assign shift  = ctl.fire & ctl.remove & (before_in | hit_reg);

    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.capture)
        begin
            if (ctl.cap_rel)
                hit_next = valid_reg && (id_reg == cmp_id);
            else
                hit_next = valid_reg && (key_reg == cmp_key) && !(&used_reg);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        used_next  = used_reg;
        id_next    = id_reg;
        if (shift)
        begin
            valid_next = nxt_valid;
            key_next   = nxt_key;
            used_next  = nxt_used;
            id_next    = nxt_id;
        end
        else if (append)
        begin
            valid_next = 1'b1;
            key_next   = req_key;
            used_next  = PLANES'(1);
            id_next    = new_id;
        end
        else if (ctl.fire && first)
        begin
            if (ctl.upd_rel)
                used_next = cleared;
            else
                used_next = used_reg | low_free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        used_reg <= used_next;
        id_reg   <= id_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign used  = used_reg;
    assign id    = id_reg;

endmodule

`default_nettype wire
